@@ rtl/axts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package axts_pkg;

    typedef enum logic [1:0] {
        ACT_START   = 2'd0,
        ACT_ENCRYPT = 2'd1,
        ACT_DECRYPT = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DKEY,
        ST_TKEY,
        ST_TENC,
        ST_LOAD,
        ST_ENC,
        ST_DEC,
        ST_FIN,
        ST_OUT
    } t_state;

    localparam logic [7:0] SBOX_ENC [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] SBOX_DEC [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX_ENC[w[31:24]], SBOX_ENC[w[23:16]], SBOX_ENC[w[15:8]], SBOX_ENC[w[7:0]]};
    endfunction

    // state byte j at bits 8j+7:8j; column c = bytes 4c..4c+3
    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
        logic [127:0] o;
        logic [7:0]   a0, a1, a2, a3;
        o = '0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                o[8*(r+4*c) +: 8] = SBOX_ENC[s[8*(r+4*((c+r)%4)) +: 8]];
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = o[32*c +: 8]; a1 = o[32*c+8 +: 8];
                a2 = o[32*c+16 +: 8]; a3 = o[32*c+24 +: 8];
                o[32*c +: 8]    = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
                o[32*c+8 +: 8]  = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
                o[32*c+16 +: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
                o[32*c+24 +: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
            end
        end
        enc_round = o;
    endfunction

    function automatic logic [127:0] dec_sub(input logic [127:0] s);
        logic [127:0] o;
        o = '0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                o[8*(r+4*((c+r)%4)) +: 8] = SBOX_DEC[s[8*(r+4*c) +: 8]];
            end
        end
        dec_sub = o;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] o;
        logic [7:0]   a [4];
        logic [7:0]   x2 [4];
        logic [7:0]   x4 [4];
        logic [7:0]   x8 [4];
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                a[r]  = s[32*c+8*r +: 8];
                x2[r] = xt(a[r]);
                x4[r] = xt(x2[r]);
                x8[r] = xt(x4[r]);
            end
            for (int r = 0; r < 4; r++) begin
                o[32*c+8*r +: 8] = (x8[r] ^ x4[r] ^ x2[r])
                    ^ (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4])
                    ^ (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4])
                    ^ (x8[(r+3)%4] ^ a[(r+3)%4]);
            end
        end
        inv_mix = o;
    endfunction

endpackage
`default_nettype wire

@@ rtl/axts_keyexp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module axts_keyexp #(
    parameter int KEY_BITS = 256
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_load,
    input  wire logic [255:0] i_key,
    input  wire logic         i_step,
    output logic      [31:0]  o_word
);
    import axts_pkg::*;

    localparam int NK = KEY_BITS / 32;
    localparam int CW = $clog2(NK);

    // sliding window of the last NK schedule words, oldest at index 0
    logic [31:0]   r_win [NK];
    logic [CW-1:0] r_phase;
    logic [7:0]    r_rcon;
    logic [31:0]   w_t;
    logic [31:0]   w_new;

    always_comb begin
        w_t = r_win[NK-1];
        if (r_phase == '0) begin
            w_t = sub_word({w_t[7:0], w_t[31:8]}) ^ {24'd0, r_rcon};
        end else if (NK > 6 && r_phase == CW'(4)) begin
            w_t = sub_word(w_t);
        end
        w_new = r_win[0] ^ w_t;
    end

    assign o_word = r_win[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_rcon  <= 8'h01;
        end else if (i_load) begin
            r_phase <= '0;
            r_rcon  <= 8'h01;
        end else if (i_step) begin
            r_phase <= (r_phase == CW'(NK - 1)) ? '0 : r_phase + 1'b1;
            if (r_phase == '0) r_rcon <= xt(r_rcon);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < NK; k++) r_win[k] <= i_key[32*k +: 32];
        end else if (i_step) begin
            for (int k = 0; k < NK - 1; k++) r_win[k] <= r_win[k+1];
            r_win[NK-1] <= w_new;
        end
    end

endmodule
`default_nettype wire

@@ rtl/aes_xts_block_cipher.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Dir | Handshake       | Payload
// s_axis   | in  | tvalid / tready | tdata, tuser = action, tlast = final_block
// m_axis   | out | tvalid / tready | tdata, tlast = unit_done
// cfg      | in  | i_cfg_we        | i_cfg_index, i_cfg_data
// Start item: two key expansions (data key, then tweak key), then NR+1 rounds
//   of tweak encryption on the shared round unit; no result.
// Block item: one round per cycle, encryption rounds through the shared round
//   unit, round keys read from the round-key memory.
// Input ready is low from acceptance until the result is taken, or until a start item finishes.
// Reset is synchronous, active low; round-key memory has no reset.
module aes_xts_block_cipher #(
    parameter int KEY_BITS = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [63:0] unit_number, [127:64] block_low, [191:128] block_high
    input  wire logic [191:0]          s_axis_tdata,
    // [1:0] action
    input  wire axts_pkg::t_action     s_axis_tuser,
    input  wire logic                  s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [63:0] result_low, [127:64] result_high
    output logic [127:0]               m_axis_tdata,
    output logic                       m_axis_tlast,
    input  wire logic                  i_cfg_we,
    input  wire logic [2:0]            i_cfg_index,
    input  wire logic [63:0]           i_cfg_data
);
    import axts_pkg::*;

    localparam int NK = KEY_BITS / 32;
    localparam int NR = NK + 6;
    localparam int NW = 4 * (NR + 1);
    localparam int RW = $clog2(NR + 2);
    localparam int WW = $clog2(NW + 1);

    logic [63:0]  r_dkey [4];
    logic [63:0]  r_tkey [4];
    logic [255:0] w_dkey;
    logic [255:0] w_tkey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_dkey[k] <= '0;
                r_tkey[k] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index[2]) r_tkey[i_cfg_index[1:0]] <= i_cfg_data;
            else r_dkey[i_cfg_index[1:0]] <= i_cfg_data;
        end
    end

    assign w_dkey = {r_dkey[3], r_dkey[2], r_dkey[1], r_dkey[0]};
    assign w_tkey = {r_tkey[3], r_tkey[2], r_tkey[1], r_tkey[0]};

    t_state         r_state, n_state;
    logic [WW-1:0]  r_cnt, n_cnt;
    logic [RW-1:0]  r_rnd, n_rnd;
    logic [127:0]   r_s, n_s;
    logic [127:0]   r_tw, n_tw;
    logic [127:0]   r_tk [NR+1];
    logic [127:0]   r_acc;
    logic           r_last, n_last;
    logic           r_dec, n_dec;
    logic [127:0]   r_out;
    logic           r_ovld, n_ovld;

    // round-key memory: one 128-bit round key per entry
    logic [127:0]   r_rkm [NR+1];
    logic [127:0]   r_rk;
    logic [RW-1:0]  w_raddr;
    logic           w_we;
    logic [RW-1:0]  w_waddr;

    logic           w_kload, w_kstep;
    logic [255:0]   w_kin;
    logic [31:0]    w_kword;

    axts_keyexp #(.KEY_BITS(KEY_BITS)) u_kexp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (w_kload),
        .i_key  (w_kin),
        .i_step (w_kstep),
        .o_word (w_kword)
    );

    // assemble 4 schedule words into a round key
    logic [127:0] n_acc;
    logic [1:0]   w_col;
    assign w_col   = r_cnt[1:0];
    assign w_waddr = RW'(r_cnt >> 2);

    always_comb begin
        n_acc = r_acc;
        n_acc[32*w_col +: 32] = w_kword;
    end

    always_ff @(posedge i_clk) begin
        if (w_kstep) r_acc <= n_acc;
        if (w_we) r_rkm[w_waddr] <= n_acc;
        r_rk <= r_rkm[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_TKEY && w_col == 2'd3) r_tk[w_waddr] <= n_acc;
    end

    logic [127:0] w_enc, w_dsub;
    assign w_enc  = enc_round(r_s, r_rnd == RW'(NR));
    assign w_dsub = dec_sub(r_s) ^ r_rk;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rnd   = r_rnd;
        n_s     = r_s;
        n_tw    = r_tw;
        n_last  = r_last;
        n_dec   = r_dec;
        n_ovld  = r_ovld;
        w_kload = 1'b0;
        w_kstep = 1'b0;
        w_kin   = w_dkey;
        w_we    = 1'b0;
        w_raddr = r_rnd;
        s_axis_tready = (r_state == ST_IDLE) && !r_ovld;
        if (r_ovld && m_axis_tready) n_ovld = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_last = s_axis_tlast;
                    n_cnt  = '0;
                    unique case (s_axis_tuser) inside
                        ACT_START: begin
                            w_kload = 1'b1;
                            n_s = {64'd0, s_axis_tdata[63:0]};
                            n_state = ST_DKEY;
                        end
                        ACT_ENCRYPT, ACT_DECRYPT: begin
                            n_s = s_axis_tdata[191:64] ^ r_tw;
                            n_dec = (s_axis_tuser == ACT_DECRYPT);
                            n_rnd = n_dec ? RW'(NR) : '0;
                            n_state = ST_LOAD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DKEY: begin
                w_kstep = 1'b1;
                w_we = (w_col == 2'd3);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == WW'(NW - 1)) begin
                    w_kload = 1'b1;
                    w_kin = w_tkey;
                    n_cnt = '0;
                    n_state = ST_TKEY;
                end
            end
            ST_TKEY: begin
                w_kstep = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == WW'(NW - 1)) begin
                    n_rnd = '0;
                    n_state = ST_TENC;
                end
            end
            ST_TENC: begin
                if (r_rnd == '0) n_s = r_s ^ r_tk[0];
                else n_s = w_enc ^ r_tk[r_rnd];
                n_rnd = r_rnd + 1'b1;
                if (r_rnd == RW'(NR)) begin
                    n_tw = n_s;
                    n_state = ST_IDLE;
                end
            end
            ST_LOAD: begin
                // key for first round is being read
                n_rnd = r_dec ? RW'(NR - 1) : RW'(1);
                n_state = r_dec ? ST_DEC : ST_ENC;
                n_s = r_s;
            end
            ST_ENC: begin
                if (r_rnd == RW'(1) && r_cnt == '0) begin
                    n_s = r_s ^ r_rk;
                    n_cnt = WW'(1);
                    w_raddr = RW'(1);
                    n_rnd = RW'(1);
                end else begin
                    n_s = w_enc ^ r_rk;
                    w_raddr = r_rnd + 1'b1;
                    n_rnd = r_rnd + 1'b1;
                    if (r_rnd == RW'(NR)) n_state = ST_FIN;
                end
            end
            ST_DEC: begin
                if (r_rnd == RW'(NR - 1) && r_cnt == '0) begin
                    n_s = r_s ^ r_rk;
                    n_cnt = WW'(1);
                    w_raddr = RW'(NR - 1);
                end else begin
                    n_s = (r_rnd == '0) ? w_dsub : inv_mix(w_dsub);
                    w_raddr = r_rnd - 1'b1;
                    n_rnd = r_rnd - 1'b1;
                    if (r_rnd == '0) n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_s = r_s ^ r_tw;
                n_tw = {r_tw[126:0], 1'b0} ^ (r_tw[127] ? 128'h87 : 128'h0);
                n_ovld = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_rnd   <= '0;
            r_tw    <= '0;
            r_ovld  <= 1'b0;
            r_dec   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rnd   <= n_rnd;
            r_tw    <= n_tw;
            r_ovld  <= n_ovld;
            r_dec   <= n_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s    <= n_s;
        r_last <= n_last;
        if (r_state == ST_FIN) r_out <= n_s;
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_out;
    assign m_axis_tlast  = r_last;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready)
        else $error("accepted while busy");
    a_fin_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |=> m_axis_tvalid)
        else $error("result not raised");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule
`default_nettype wire
